/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the core rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on clk_i, quiet while rst_ni is low
`define CFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on clk_i at every edge, reset included
`define CFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/cft_pkg.sv */
// ----------------------------------------------------------------------------
// cft_pkg
// types and codes shared by the cube map face / texcoord pipeline
// ----------------------------------------------------------------------------
package cft_pkg;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  // per-request control that rides along the divider chain
  typedef struct packed {
    face_e face;
    logic  zero;
    logic  sat_u;
    logic  sat_v;
  } ctl_t;

endpackage

/* rtl/core/cubemap_face_texcoord.sv */
// ----------------------------------------------------------------------------
// cubemap_face_texcoord
// cube map face selection with face-local u/v in unsigned fixed point
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+----------------------------------
//   in      | in_valid_i  | in_stall_o   | dir_x_i dir_y_i dir_z_i
//   out     | out_valid_o | out_stall_i  | face_o tex_u_o tex_v_o zero_dir_o
//
// one request per cycle while in_stall_o is low; one setup stage,
// then one divider cell per quotient bit
// each cell moves on when its successor is empty or moving, so bubbles close up
// in_stall_o is high only when every stage holds a request and out is stalled
// reset clears the stage valids only
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cubemap_face_texcoord #(
  parameter int IN_BITS  = 16,
  parameter int OUT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [IN_BITS-1:0] dir_x_i,
  input  logic signed [IN_BITS-1:0] dir_y_i,
  input  logic signed [IN_BITS-1:0] dir_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                face_o,
  output logic [OUT_BITS-1:0]       tex_u_o,
  output logic [OUT_BITS-1:0]       tex_v_o,
  output logic                      zero_dir_o
);

  localparam int NS = OUT_BITS + 1;

  logic                st_valid [NS];
  logic                st_stall [NS+1];
  cft_pkg::ctl_t       st_ctl   [NS];
  logic [IN_BITS:0]    st_den   [NS];
  logic [IN_BITS:0]    st_r_u   [NS];
  logic [IN_BITS:0]    st_r_v   [NS];
  logic [OUT_BITS-1:0] st_q_u   [NS];
  logic [OUT_BITS-1:0] st_q_v   [NS];

  cft_prep #(
    .IN_BITS (IN_BITS),
    .OUT_BITS(OUT_BITS)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .stall_o(st_stall[0]),
    .dir_x_i(dir_x_i),
    .dir_y_i(dir_y_i),
    .dir_z_i(dir_z_i),
    .valid_o(st_valid[0]),
    .stall_i(st_stall[1]),
    .ctl_o  (st_ctl[0]),
    .den_o  (st_den[0]),
    .r_u_o  (st_r_u[0]),
    .r_v_o  (st_r_v[0]),
    .q_u_o  (st_q_u[0]),
    .q_v_o  (st_q_v[0])
  );

  for (genvar g = 1; g < NS; g++) begin : g_cell
    cft_div_cell #(
      .IN_BITS (IN_BITS),
      .OUT_BITS(OUT_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(st_valid[g-1]),
      .stall_o(st_stall[g]),
      .ctl_i  (st_ctl[g-1]),
      .den_i  (st_den[g-1]),
      .r_u_i  (st_r_u[g-1]),
      .r_v_i  (st_r_v[g-1]),
      .q_u_i  (st_q_u[g-1]),
      .q_v_i  (st_q_v[g-1]),
      .valid_o(st_valid[g]),
      .stall_i(st_stall[g+1]),
      .ctl_o  (st_ctl[g]),
      .den_o  (st_den[g]),
      .r_u_o  (st_r_u[g]),
      .r_v_o  (st_r_v[g]),
      .q_u_o  (st_q_u[g]),
      .q_v_o  (st_q_v[g])
    );
  end

  assign st_stall[NS] = out_stall_i;
  assign in_stall_o   = st_stall[0];

  cft_pkg::ctl_t last_ctl;
  assign last_ctl = st_ctl[NS-1];

  // a coordinate exactly at the far edge would be 1.0 and clamps to all ones
  assign out_valid_o = st_valid[NS-1];
  assign face_o      = last_ctl.face;
  assign zero_dir_o  = last_ctl.zero;
  assign tex_u_o     = last_ctl.zero  ? '0 :
                       last_ctl.sat_u ? '1 : st_q_u[NS-1];
  assign tex_v_o     = last_ctl.zero  ? '0 :
                       last_ctl.sat_v ? '1 : st_q_v[NS-1];

  `CFT_ASSERT(a_zero_face, out_valid_o && zero_dir_o |-> face_o == cft_pkg::FACE_NZ, "zero vector not on -Z face")
  `CFT_ASSERT(a_full_stall, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output backpressure")
  `CFT_ASSERT(a_rem_bound, out_valid_o && !zero_dir_o |-> st_r_u[NS-1] < st_den[NS-1] || last_ctl.sat_u, "u remainder out of range")
  `CFT_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid right after reset")

endmodule

/* rtl/core/cft_prep.sv */
// ----------------------------------------------------------------------------
// cft_prep
// face pick, major axis magnitude and coordinate numerators, one register
// ----------------------------------------------------------------------------
module cft_prep #(
  parameter int IN_BITS  = 16,
  parameter int OUT_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic signed [IN_BITS-1:0]  dir_x_i,
  input  logic signed [IN_BITS-1:0]  dir_y_i,
  input  logic signed [IN_BITS-1:0]  dir_z_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output cft_pkg::ctl_t              ctl_o,
  output logic        [IN_BITS:0]    den_o,
  output logic        [IN_BITS:0]    r_u_o,
  output logic        [IN_BITS:0]    r_v_o,
  output logic        [OUT_BITS-1:0] q_u_o,
  output logic        [OUT_BITS-1:0] q_v_o
);

  localparam int EW = IN_BITS + 1;

  logic signed [EW-1:0]    xe, ye, ze;
  logic signed [EW-1:0]    xa, ya, za;
  logic        [IN_BITS-1:0] ax, ay, az;
  logic        [IN_BITS-1:0] m;
  logic signed [EW-1:0]    a, b;
  logic signed [EW:0]      sum_u, sum_v;
  logic        [IN_BITS:0] num_u, num_v, den;
  cft_pkg::face_e          face;
  logic                    zero;

  logic                    valid_q;
  cft_pkg::ctl_t           ctl_q;
  logic        [IN_BITS:0] den_q, r_u_q, r_v_q;

  assign xe = {dir_x_i[IN_BITS-1], dir_x_i};
  assign ye = {dir_y_i[IN_BITS-1], dir_y_i};
  assign ze = {dir_z_i[IN_BITS-1], dir_z_i};

  // one extra bit so the most negative input has a magnitude in xa/ya/za; ax/ay/az drop it
  assign xa = xe[EW-1] ? -xe : xe;
  assign ya = ye[EW-1] ? -ye : ye;
  assign za = ze[EW-1] ? -ze : ze;
  assign ax = xa[IN_BITS-1:0];
  assign ay = ya[IN_BITS-1:0];
  assign az = za[IN_BITS-1:0];

  assign zero = (dir_x_i == '0) && (dir_y_i == '0) && (dir_z_i == '0);

  // strict compares: ties never go to x, and y/z ties go to z
  always_comb begin
    priority if ((ax > ay) && (ax > az)) begin
      m = ax;
      if (!xe[EW-1] && (dir_x_i != '0)) begin
        face = cft_pkg::FACE_PX;
        a    = ze;
      end else begin
        face = cft_pkg::FACE_NX;
        a    = -ze;
      end
      b = ye;
    end else if (ay > az) begin
      m = ay;
      a = xe;
      if (!ye[EW-1] && (dir_y_i != '0)) begin
        face = cft_pkg::FACE_PY;
        b    = ze;
      end else begin
        face = cft_pkg::FACE_NY;
        b    = -ze;
      end
    end else begin
      m = az;
      b = ye;
      if (!ze[EW-1] && (dir_z_i != '0)) begin
        face = cft_pkg::FACE_PZ;
        a    = -xe;
      end else begin
        face = cft_pkg::FACE_NZ;
        a    = xe;
      end
    end
  end

  // (a + m) / (2m): numerator lies in 0..2m
  assign sum_u = {a[EW-1], a} + $signed({2'b00, m});
  assign sum_v = {b[EW-1], b} + $signed({2'b00, m});
  assign num_u = sum_u[IN_BITS:0];
  assign num_v = sum_v[IN_BITS:0];
  assign den   = {m, 1'b0};

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      ctl_q.face  <= face;
      ctl_q.zero  <= zero;
      ctl_q.sat_u <= (num_u == den);
      ctl_q.sat_v <= (num_v == den);
      den_q       <= den;
      r_u_q       <= num_u;
      r_v_q       <= num_v;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign den_o   = den_q;
  assign r_u_o   = r_u_q;
  assign r_v_o   = r_v_q;
  assign q_u_o   = '0;
  assign q_v_o   = '0;

endmodule

/* rtl/core/cft_div_cell.sv */
// ----------------------------------------------------------------------------
// cft_div_cell
// one restoring division step for both coordinates, registered
// ----------------------------------------------------------------------------
module cft_div_cell #(
  parameter int IN_BITS  = 16,
  parameter int OUT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  cft_pkg::ctl_t         ctl_i,
  input  logic [IN_BITS:0]      den_i,
  input  logic [IN_BITS:0]      r_u_i,
  input  logic [IN_BITS:0]      r_v_i,
  input  logic [OUT_BITS-1:0]   q_u_i,
  input  logic [OUT_BITS-1:0]   q_v_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output cft_pkg::ctl_t         ctl_o,
  output logic [IN_BITS:0]      den_o,
  output logic [IN_BITS:0]      r_u_o,
  output logic [IN_BITS:0]      r_v_o,
  output logic [OUT_BITS-1:0]   q_u_o,
  output logic [OUT_BITS-1:0]   q_v_o
);

  logic [IN_BITS+1:0]  r2_u, r2_v, dd_u, dd_v;
  logic                bit_u, bit_v;
  logic [IN_BITS:0]    r_u_d, r_v_d;
  logic [OUT_BITS-1:0] q_u_d, q_v_d;

  logic                valid_q;
  cft_pkg::ctl_t       ctl_q;
  logic [IN_BITS:0]    den_q, r_u_q, r_v_q;
  logic [OUT_BITS-1:0] q_u_q, q_v_q;

  assign r2_u  = {r_u_i, 1'b0};
  assign r2_v  = {r_v_i, 1'b0};
  assign dd_u  = r2_u - {1'b0, den_i};
  assign dd_v  = r2_v - {1'b0, den_i};
  assign bit_u = (r2_u >= {1'b0, den_i});
  assign bit_v = (r2_v >= {1'b0, den_i});
  assign r_u_d = bit_u ? dd_u[IN_BITS:0] : r2_u[IN_BITS:0];
  assign r_v_d = bit_v ? dd_v[IN_BITS:0] : r2_v[IN_BITS:0];
  assign q_u_d = {q_u_i[OUT_BITS-2:0], bit_u};
  assign q_v_d = {q_v_i[OUT_BITS-2:0], bit_v};

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      ctl_q <= ctl_i;
      den_q <= den_i;
      r_u_q <= r_u_d;
      r_v_q <= r_v_d;
      q_u_q <= q_u_d;
      q_v_q <= q_v_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign den_o   = den_q;
  assign r_u_o   = r_u_q;
  assign r_v_o   = r_v_q;
  assign q_u_o   = q_u_q;
  assign q_v_o   = q_v_q;

endmodule
